>>> rtl/separable_2d_fir_filter_top_assert.svh
// assertion macros used by the filter back end
`ifndef SEPARABLE_2D_FIR_FILTER_TOP_ASSERT_SVH
`define SEPARABLE_2D_FIR_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SFIR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sfir assertion failed");
`define SFIR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfir assertion failed");
`else
`define SFIR_ASSERT(lbl, prop)
`define SFIR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/sfir_pkg.sv
package sfir_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_TAPS  = 16;

   // operation codes
   localparam logic [1:0] OP_PIXEL    = 2'd0;
   localparam logic [1:0] OP_ROW_COEF = 2'd1;
   localparam logic [1:0] OP_COL_COEF = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_WIDTH      = 3'd0;
   localparam logic [2:0] REG_HEIGHT     = 3'd1;
   localparam logic [2:0] REG_ROW_TAPS   = 3'd2;
   localparam logic [2:0] REG_COL_TAPS   = 3'd3;
   localparam logic [2:0] REG_ACCUMULATE = 3'd4;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 64;

   typedef struct packed {
      logic [10:0] image_width;
      logic [15:0] image_height;
      logic [4:0]  row_taps;
      logic [4:0]  col_taps;
      logic        accumulate;
   } cfg_type;

   // width of one queue entry for given column and slot widths
   function automatic int item_bits(input int cw, input int sw);
      return 2 + 4 + 16 + 16 + 32 + 3 + cw + 16 + 2 * sw;
   endfunction

endpackage

>>> rtl/sfir_ram.sv
module sfir_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/sfir_queue.sv
module sfir_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   // two-entry queue between front and back
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
endmodule

>>> rtl/sfir_front.sv
module sfir_front #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_TAPS  = 16,
   parameter int QW        = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sfir_pkg::cfg_type                  cfg,
   input  logic                               cfg_clear,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sfir_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [1:0]                         req_tuser,
   input  logic                               q_full,
   output logic                               q_push,
   output logic [QW-1:0]                      q_data
);
   import sfir_pkg::*;

   localparam int WIN = MAX_TAPS - 1;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int TW  = $clog2(MAX_TAPS + 1);
   localparam int SW  = $clog2(MAX_TAPS);
   localparam int NW  = (CW + 1 > TW) ? CW + 1 : TW;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        tap_index;
      logic [15:0]       coefficient_value;
      logic [15:0]       pixel;
      logic [31:0]       addend;
      logic              row_ok;
      logic              produce;
      logic              last;
      logic [CW-1:0]     ocol;
      logic [15:0]       out_row;
      logic [SW-1:0]     rd_slot;
      logic [SW-1:0]     wr_slot;
   } q_item_type;

   logic [CW-1:0]   col_ff, col_in;
   logic [15:0]     row_ff, row_in;
   logic [SW-1:0]   rs_ff, rs_in;
   logic [WW-1:0]   w_eff;
   logic [15:0]     h_eff;
   logic [TW-1:0]   rt_eff, ct_eff;
   logic [CW:0]     col_inc;
   logic [16:0]     row_inc;
   logic [SW:0]     rd_tmp;
   logic            accept;
   logic [1:0]      op;
   q_item_type      item;

   // effective geometry
   always_comb begin
      if (cfg.image_width == 11'd0) begin
         w_eff = WW'(1);
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg.image_width);
      end
      h_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
      if (cfg.row_taps == 5'd0) begin
         rt_eff = TW'(1);
      end else if (32'(cfg.row_taps) > MAX_TAPS) begin
         rt_eff = TW'(MAX_TAPS);
      end else begin
         rt_eff = TW'(cfg.row_taps);
      end
      if (cfg.col_taps == 5'd0) begin
         ct_eff = TW'(1);
      end else if (32'(cfg.col_taps) > MAX_TAPS) begin
         ct_eff = TW'(MAX_TAPS);
      end else begin
         ct_eff = TW'(cfg.col_taps);
      end
   end

   assign op         = req_tuser;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && (op != OP_UNUSED);

   // classify the item and work out its position
   always_comb begin
      col_inc = {1'b0, col_ff} + (CW+1)'(1);
      row_inc = {1'b0, row_ff} + 17'd1;
      rd_tmp  = (SW+1)'(rs_ff) + (SW+1)'(WIN) - (SW+1)'(ct_eff - TW'(1));
      item.kind              = op;
      item.pixel             = req_tdata[15:0];
      item.tap_index         = req_tdata[19:16];
      item.coefficient_value = req_tdata[35:20];
      item.addend            = req_tdata[67:36];
      item.row_ok            = (NW'(col_inc) >= NW'(rt_eff));
      item.produce           = item.row_ok && (row_inc >= 17'(ct_eff));
      item.last              = (NW'(col_inc) == NW'(w_eff)) && (row_inc == {1'b0, h_eff});
      item.ocol              = CW'(NW'(col_inc) - NW'(rt_eff));
      item.out_row           = 16'(row_inc - 17'(ct_eff));
      item.rd_slot           = (rd_tmp >= (SW+1)'(WIN)) ? SW'(rd_tmp - (SW+1)'(WIN))
                                                        : SW'(rd_tmp);
      item.wr_slot           = rs_ff;
   end

   assign q_data = QW'(item);

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      rs_in  = rs_ff;
      if (accept && op == OP_PIXEL) begin
         if (32'(col_inc) >= 32'(w_eff)) begin
            col_in = '0;
            if (row_inc >= {1'b0, h_eff}) begin
               row_in = 16'd0;
               rs_in  = '0;
            end else begin
               row_in = row_inc[15:0];
               rs_in  = (rs_ff == SW'(WIN - 1)) ? '0 : rs_ff + SW'(1);
            end
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         col_ff <= '0;
         row_ff <= 16'd0;
         rs_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         rs_ff  <= rs_in;
      end
   end
endmodule

>>> rtl/sfir_back.sv
`include "separable_2d_fir_filter_top_assert.svh"
module sfir_back #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_TAPS  = 16,
   parameter int QW        = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sfir_pkg::cfg_type               cfg,
   input  logic [QW-1:0]                   q_data,
   input  logic                            q_empty,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sfir_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import sfir_pkg::*;

   localparam int WIN   = MAX_TAPS - 1;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int TW    = $clog2(MAX_TAPS + 1);
   localparam int SW    = $clog2(MAX_TAPS);
   localparam int KW    = $clog2(MAX_TAPS);
   localparam int DEPTH = WIN * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        tap_index;
      logic [15:0]       coefficient_value;
      logic [15:0]       pixel;
      logic [31:0]       addend;
      logic              row_ok;
      logic              produce;
      logic              last;
      logic [CW-1:0]     ocol;
      logic [15:0]       out_row;
      logic [SW-1:0]     rd_slot;
      logic [SW-1:0]     wr_slot;
   } q_item_type;

   typedef enum logic [3:0] {
      IDLE, ROW_MUL, ROW_ADD, ROW_RND, COL_RD, COL_MUL, COL_ADD, COL_RND, WR_BACK
   } state_type;

   state_type           state_ff;
   q_item_type          q_item, cur_ff;
   logic signed [15:0]  win_ff   [WIN];
   logic signed [15:0]  rcoef_ff [MAX_TAPS];
   logic signed [15:0]  ccoef_ff [MAX_TAPS];
   logic [KW-1:0]       k_ff;
   logic [SW-1:0]       slot_ff;
   logic signed [47:0]  acc_ff;
   logic signed [39:0]  prod_ff;
   logic signed [23:0]  hval_ff;
   logic                rsp_valid_ff;
   logic [31:0]         rsp_value_ff;
   logic [15:0]         rsp_row_ff;
   logic [9:0]          rsp_col_ff;
   logic                rsp_last_ff;

   logic [TW-1:0]       rt_eff, ct_eff, k_inc;
   logic [TW-1:0]       widx_full;
   logic signed [23:0]  mul_a;
   logic signed [15:0]  mul_b;
   logic signed [47:0]  rnd, prod_ext;
   logic signed [23:0]  sat24;
   logic signed [31:0]  sat32, final_value;
   logic signed [32:0]  sum33;
   logic                out_free, row_last_tap, col_last_tap;
   logic                ram_wr, ram_rd;
   logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
   logic [23:0]         ram_rd_data;

   assign q_item = q_item_type'(q_data);

   always_comb begin
      if (cfg.row_taps == 5'd0) begin
         rt_eff = TW'(1);
      end else if (32'(cfg.row_taps) > MAX_TAPS) begin
         rt_eff = TW'(MAX_TAPS);
      end else begin
         rt_eff = TW'(cfg.row_taps);
      end
      if (cfg.col_taps == 5'd0) begin
         ct_eff = TW'(1);
      end else if (32'(cfg.col_taps) > MAX_TAPS) begin
         ct_eff = TW'(MAX_TAPS);
      end else begin
         ct_eff = TW'(cfg.col_taps);
      end
   end

   assign k_inc        = TW'(k_ff) + TW'(1);
   assign row_last_tap = (k_inc == rt_eff);
   assign col_last_tap = (k_inc == ct_eff);
   assign widx_full    = rt_eff - TW'(2) - TW'(k_ff);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign q_pop        = (state_ff == IDLE) && !q_empty;

   // multiplier operands: the current pixel or a window tap, hval or a stored row
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ROW_MUL: begin
            mul_a = row_last_tap ? 24'(signed'(cur_ff.pixel))
                                 : 24'(win_ff[SW'(widx_full)]);
            mul_b = rcoef_ff[k_ff];
         end
         COL_MUL: begin
            mul_a = col_last_tap ? hval_ff : signed'(ram_rd_data);
            mul_b = ccoef_ff[k_ff];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // round half up, then saturate; in accumulate mode add the addend with saturation
   always_comb begin
      prod_ext = 48'(prod_ff);
      rnd      = (acc_ff + 48'sd8192) >>> 14;
      if (rnd > 48'sd8388607) begin
         sat24 = 24'sh7FFFFF;
      end else if (rnd < -48'sd8388608) begin
         sat24 = 24'sh800000;
      end else begin
         sat24 = rnd[23:0];
      end
      if (rnd > 48'sd2147483647) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (rnd < -48'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = rnd[31:0];
      end
      sum33 = 33'(sat32) + 33'(signed'(cur_ff.addend));
      if (!cfg.accumulate) begin
         final_value = sat32;
      end else if (sum33[32] != sum33[31]) begin
         final_value = sum33[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         final_value = sum33[31:0];
      end
   end

   // line store access
   assign ram_rd      = (state_ff == COL_RD) && !col_last_tap;
   assign ram_rd_addr = AW'(slot_ff * MAX_WIDTH + cur_ff.ocol);
   assign ram_wr      = (state_ff == WR_BACK);
   assign ram_wr_addr = AW'(cur_ff.wr_slot * MAX_WIDTH + cur_ff.ocol);

   sfir_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_wr_addr),
      .wr_data (hval_ff),
      .rd_en   (ram_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer: one tap per multiply and add step
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WIN; i++) begin
            win_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_TAPS; i++) begin
            rcoef_ff[i] <= '0;
            ccoef_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != COL_RND)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (!q_empty) begin
                  cur_ff <= q_item;
                  k_ff   <= '0;
                  acc_ff <= '0;
                  case (q_item.kind)
                     OP_ROW_COEF: begin
                        if (32'(q_item.tap_index) < MAX_TAPS) begin
                           rcoef_ff[KW'(q_item.tap_index)] <= q_item.coefficient_value;
                        end
                     end
                     OP_COL_COEF: begin
                        if (32'(q_item.tap_index) < MAX_TAPS) begin
                           ccoef_ff[KW'(q_item.tap_index)] <= q_item.coefficient_value;
                        end
                     end
                     OP_PIXEL: begin
                        if (q_item.row_ok) begin
                           state_ff <= ROW_MUL;
                        end else begin
                           for (int i = WIN - 1; i > 0; i--) begin
                              win_ff[i] <= win_ff[i-1];
                           end
                           win_ff[0] <= q_item.pixel;
                        end
                     end
                     default: begin
                        state_ff <= IDLE;
                     end
                  endcase
               end
            end
            ROW_MUL: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= ROW_ADD;
            end
            ROW_ADD: begin
               acc_ff <= acc_ff + prod_ext;
               if (row_last_tap) begin
                  state_ff <= ROW_RND;
               end else begin
                  k_ff     <= k_ff + KW'(1);
                  state_ff <= ROW_MUL;
               end
            end
            ROW_RND: begin
               hval_ff  <= sat24;
               acc_ff   <= '0;
               k_ff     <= '0;
               slot_ff  <= cur_ff.rd_slot;
               state_ff <= cur_ff.produce ? COL_RD : WR_BACK;
            end
            COL_RD: begin
               state_ff <= COL_MUL;
            end
            COL_MUL: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= COL_ADD;
            end
            COL_ADD: begin
               acc_ff  <= acc_ff + prod_ext;
               slot_ff <= (slot_ff == SW'(WIN - 1)) ? '0 : slot_ff + SW'(1);
               if (col_last_tap) begin
                  state_ff <= COL_RND;
               end else begin
                  k_ff     <= k_ff + KW'(1);
                  state_ff <= COL_RD;
               end
            end
            COL_RND: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= final_value;
                  rsp_row_ff   <= cur_ff.out_row;
                  rsp_col_ff   <= 10'(cur_ff.ocol);
                  rsp_last_ff  <= cur_ff.last;
                  state_ff     <= WR_BACK;
               end
            end
            WR_BACK: begin
               for (int i = WIN - 1; i > 0; i--) begin
                  win_ff[i] <= win_ff[i-1];
               end
               win_ff[0] <= cur_ff.pixel;
               state_ff  <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   // rsp_tdata: result_value [31:0], out_row [47:32], out_col [57:48], zero pad
   assign rsp_tdata  = {6'd0, rsp_col_ff, rsp_row_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   `SFIR_ASSERT_NEXT(a_result_loaded, state_ff == COL_RND && out_free, rsp_valid_ff)
   `SFIR_ASSERT(a_store_write_row_ok, ram_wr |-> cur_ff.row_ok)
   `SFIR_ASSERT(a_read_only_produce, ram_rd |-> cur_ff.produce)
   `SFIR_ASSERT(a_row_tap_bound, state_ff == ROW_ADD |-> k_inc <= rt_eff)
endmodule

>>> rtl/separable_2d_fir_filter_top.sv
// separable 2-d fir filter, valid region, with optional accumulate
// each pixel runs through the row taps, and an output pixel then through the column taps;
// the back end takes one queued item at a time and does not pop the next until it is
// done with the last; coefficient writes and pixels left of the row window are handled
// in IDLE; the multiply-accumulate unit and line store are shared
// reset: synchronous, active high; clears counters, coefficients and the window
module separable_2d_fir_filter_top #(
   parameter int MAX_WIDTH = sfir_pkg::DEF_MAX_WIDTH,
   parameter int MAX_TAPS  = sfir_pkg::DEF_MAX_TAPS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [2:0]                      csr_index,
   input  logic [15:0]                     csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata: pixel [15:0], tap_index [19:16], coefficient_value [35:20],
   // addend [67:36], zero pad
   input  logic [sfir_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: operation [1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: result_value [31:0], out_row [47:32], out_col [57:48], zero pad
   output logic [sfir_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import sfir_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int SW = $clog2(MAX_TAPS);
   localparam int QW = item_bits(CW, SW);

   cfg_type        cfg_ff;
   logic           cfg_clear;
   logic           q_push, q_pop, q_full, q_empty;
   logic [QW-1:0]  q_wdata, q_rdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 11'd1024;
         cfg_ff.image_height <= 16'd1;
         cfg_ff.row_taps     <= 5'd1;
         cfg_ff.col_taps     <= 5'd1;
         cfg_ff.accumulate   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_WIDTH:      cfg_ff.image_width  <= csr_wdata[10:0];
            REG_HEIGHT:     cfg_ff.image_height <= csr_wdata;
            REG_ROW_TAPS:   cfg_ff.row_taps     <= csr_wdata[4:0];
            REG_COL_TAPS:   cfg_ff.col_taps     <= csr_wdata[4:0];
            REG_ACCUMULATE: cfg_ff.accumulate   <= csr_wdata[0];
            default:        cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign cfg_clear = csr_we && (csr_index <= REG_ACCUMULATE);

   sfir_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_TAPS(MAX_TAPS), .QW(QW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cfg_clear  (cfg_clear),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   sfir_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   sfir_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_TAPS(MAX_TAPS), .QW(QW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_data     (q_rdata),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
